// File: design/slgs_pkg.sv
// Package for the sea-level-gated smoothing filter: widths, arithmetic constants,
// payload structs and the sequencer state type. No dependencies.
`default_nettype none

package slgs_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 4096;
    localparam int HEIGHT_BITS = 24;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int COL_W       = 10;
    localparam int ROW_W       = 12;
    localparam int CNT_W       = 11;
    localparam int WCFG_W      = 11;
    localparam int HCFG_W      = 13;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int WORD_W      = 2 * HEIGHT_BITS;

    // filter arithmetic widths
    localparam int SUM_W        = HEIGHT_BITS + 3;
    localparam int Q_W          = SUM_W + 18;
    localparam int P_W          = Q_W + 15;
    localparam int EDGE_SHIFT   = 16;
    localparam int ROUND_SHIFT  = 32;
    localparam int R_W          = P_W - ROUND_SHIFT;

    localparam logic signed [17:0] DIAG_WEIGHT  = 18'sd46341;
    localparam logic signed [14:0] SCALE_WEIGHT = 15'sd8372;
    localparam logic signed [P_W-1:0] ROUND_HALF = P_W'(64'sd1 <<< (ROUND_SHIFT - 1));
    localparam logic signed [R_W-1:0] RES_MAX =
        R_W'((64'sd1 <<< (HEIGHT_BITS - 1)) - 64'sd1);
    localparam logic signed [R_W-1:0] RES_MIN =
        R_W'(-(64'sd1 <<< (HEIGHT_BITS - 1)));

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEA_LEVEL    = 2'd2;

    localparam logic [WCFG_W-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [HCFG_W-1:0] HEIGHT_RESET = 13'd1024;

    typedef logic signed [HEIGHT_BITS-1:0] height_t;

    typedef struct packed {
        height_t sample_height;
        logic    pad;
    } in_t;

    typedef struct packed {
        height_t            smoothed_height;
        logic [COL_W-1:0]   column;
        logic [ROW_W-1:0]   row;
        logic               frame_end;
    } out_t;

    // position and gating info that travels with one result through the filter
    typedef struct packed {
        logic [COL_W-1:0]   column;
        logic [ROW_W-1:0]   row;
        logic               frame_end;
        logic               border;
    } ctx_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CALC
    } state_t;

endpackage

`default_nettype wire

// File: design/slgs_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module slgs_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 48
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: design/slgs_filter.sv
// Three-stage weighted 3x3 smoothing datapath with sea-level gating and saturation.
// Depends on slgs_pkg.
`default_nettype none

module slgs_filter (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic             take,
    input  slgs_pkg::height_t     window [3][3],
    input  slgs_pkg::height_t     sea_level,
    input  slgs_pkg::ctx_t        ctx,
    output logic                  result_valid,
    output slgs_pkg::out_t        result
);

    localparam int SUM_W = slgs_pkg::SUM_W;
    localparam int Q_W   = slgs_pkg::Q_W;
    localparam int P_W   = slgs_pkg::P_W;
    localparam int R_W   = slgs_pkg::R_W;
    localparam int HB    = slgs_pkg::HEIGHT_BITS;

    logic v1_reg, v2_reg, v3_reg;
    logic v3_next;

    logic signed [SUM_W-1:0] sum_edge_reg, sum_edge_next;
    logic signed [SUM_W-1:0] sum_diag_reg, sum_diag_next;
    logic signed [Q_W-1:0]   q_reg, q_next, diag_mul;
    logic signed [P_W-1:0]   prod_reg, prod_next, scale_mul;
    logic signed [R_W-1:0]   rounded, saturated;

    slgs_pkg::ctx_t    ctx1_reg, ctx2_reg, ctx3_reg;
    slgs_pkg::height_t ctr1_reg, ctr2_reg, ctr3_reg;
    logic              byp1_reg, byp2_reg, byp3_reg;

    // stage 1: neighbourhood sums
    always_comb begin
        sum_edge_next = SUM_W'(window[1][1]) + SUM_W'(window[0][1]) + SUM_W'(window[2][1])
                      + SUM_W'(window[1][0]) + SUM_W'(window[1][2]);
        sum_diag_next = SUM_W'(window[0][0]) + SUM_W'(window[0][2])
                      + SUM_W'(window[2][0]) + SUM_W'(window[2][2]);
    end

    // stage 2: weighted sum
    assign diag_mul = sum_diag_reg * slgs_pkg::DIAG_WEIGHT;
    assign q_next   = (Q_W'(sum_edge_reg) <<< slgs_pkg::EDGE_SHIFT) + diag_mul;

    // stage 3: scale with round half up
    assign scale_mul = q_reg * slgs_pkg::SCALE_WEIGHT;
    assign prod_next = scale_mul + slgs_pkg::ROUND_HALF;

    assign v3_next = v2_reg ? 1'b1 : (v3_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            sum_edge_reg <= sum_edge_next;
            sum_diag_reg <= sum_diag_next;
            ctx1_reg     <= ctx;
            ctr1_reg     <= window[1][1];
            byp1_reg     <= ctx.border || (window[1][1] <= sea_level);
        end
        if (v1_reg) begin
            q_reg    <= q_next;
            ctx2_reg <= ctx1_reg;
            ctr2_reg <= ctr1_reg;
            byp2_reg <= byp1_reg;
        end
        if (v2_reg) begin
            prod_reg <= prod_next;
            ctx3_reg <= ctx2_reg;
            ctr3_reg <= ctr2_reg;
            byp3_reg <= byp2_reg;
        end
    end

    always_comb begin
        rounded = prod_reg[P_W-1:slgs_pkg::ROUND_SHIFT];
        if (rounded > slgs_pkg::RES_MAX) begin
            saturated = slgs_pkg::RES_MAX;
        end else if (rounded < slgs_pkg::RES_MIN) begin
            saturated = slgs_pkg::RES_MIN;
        end else begin
            saturated = rounded;
        end
        result.smoothed_height = byp3_reg ? ctr3_reg : saturated[HB-1:0];
        result.column          = ctx3_reg.column;
        result.row             = ctx3_reg.row;
        result.frame_end       = ctx3_reg.frame_end;
    end

    assign result_valid = v3_reg;

endmodule

`default_nettype wire

// File: design/sea_level_gated_smoothing.sv
// Top level of the sea-level-gated 3x3 smoothing filter.
// Depends on slgs_pkg, slgs_ram and slgs_filter.
`default_nettype none

// Streams a height map in raster order (signed Q7.16, one sample per input
// transfer) and returns a smoothed map in the same order, lagging the input by
// image_width+1 samples. Interior samples above sea_level are replaced by a 3x3
// weighted average (edges weight 1, diagonals 1/sqrt2, normalized, rounded half
// up, saturated); border samples and samples at or below sea_level pass through.
// Each result carries its column, row and a frame_end flag. After the last
// sample of a frame, send pad transfers (pad=1) to flush the image_width+1
// pending results; pads at any other time are dropped. New samples push out
// an unflushed tail, a partly flushed one is dropped. Writing image_width or
// image_height restarts the stream; sea_level takes effect at once. Write
// configuration only while idle. Both line buffers share one 1024 x 48 RAM
// that is read on accept and written back in the next cycle; no clearing pass
// is needed after reset. A dropped pad is done at accept alone, a sample that
// yields no result goes through accept and the line buffer read-modify-write,
// and one that yields a result through accept, read-modify-write, three
// arithmetic stages and output load, which waits for a free output register.
module sea_level_gated_smoothing (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // sample input
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  slgs_pkg::in_t                           s_data,
    // result output
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output slgs_pkg::out_t                          m_data,
    // configuration write
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [slgs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [slgs_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int COL_W  = slgs_pkg::COL_W;
    localparam int ROW_W  = slgs_pkg::ROW_W;
    localparam int CNT_W  = slgs_pkg::CNT_W;
    localparam int WCFG_W = slgs_pkg::WCFG_W;
    localparam int HCFG_W = slgs_pkg::HCFG_W;
    localparam int ADDR_W = slgs_pkg::ADDR_W;
    localparam int HB     = slgs_pkg::HEIGHT_BITS;
    localparam int WORD_W = slgs_pkg::WORD_W;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    slgs_pkg::state_t state_reg, state_next;

    logic [WCFG_W-1:0]  width_reg, width_next;
    logic [HCFG_W-1:0]  height_reg, height_next;
    slgs_pkg::height_t  sea_reg, sea_next;

    logic [COL_W-1:0]   in_col_reg, in_col_next;
    logic [ROW_W-1:0]   in_row_reg, in_row_next;
    logic [COL_W-1:0]   out_col_reg, out_col_next;
    logic [ROW_W-1:0]   out_row_reg, out_row_next;
    logic [CNT_W-1:0]   pending_reg, pending_next;

    // item in flight
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    slgs_pkg::height_t  value_reg, value_next;
    logic               emit_reg, emit_next;
    slgs_pkg::ctx_t     ctx_reg, ctx_next;

    slgs_pkg::height_t  window_reg  [3][3];
    slgs_pkg::height_t  window_next [3][3];

    logic               m_valid_reg, m_valid_next;
    slgs_pkg::out_t     m_data_reg, m_data_next;

    // effective geometry
    logic [WCFG_W-1:0]  w_eff;
    logic [HCFG_W-1:0]  h_eff;
    logic [WCFG_W-1:0]  w_dec;
    logic [HCFG_W-1:0]  h_dec;
    logic [COL_W-1:0]   w_m1;
    logic [ROW_W-1:0]   h_m1;
    logic [CNT_W-1:0]   w_p1;

    // RAM and filter hookup
    logic               ram_re, ram_we;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [WORD_W-1:0]  ram_wdata, ram_rdata;
    logic               f_start, f_take, f_valid;
    slgs_pkg::out_t     f_result;

    logic               in_xfer;

    assign s_ready   = (state_reg == slgs_pkg::S_IDLE);
    assign in_xfer   = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // clamp geometry to the supported range
    always_comb begin
        if (width_reg < WCFG_W'(3)) begin
            w_eff = WCFG_W'(3);
        end else if (width_reg > WCFG_W'(slgs_pkg::MAX_WIDTH)) begin
            w_eff = WCFG_W'(slgs_pkg::MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        if (height_reg < HCFG_W'(3)) begin
            h_eff = HCFG_W'(3);
        end else if (height_reg > HCFG_W'(slgs_pkg::MAX_HEIGHT)) begin
            h_eff = HCFG_W'(slgs_pkg::MAX_HEIGHT);
        end else begin
            h_eff = height_reg;
        end
        w_dec = w_eff - WCFG_W'(1);
        h_dec = h_eff - HCFG_W'(1);
        w_m1  = w_dec[COL_W-1:0];
        h_m1  = h_dec[ROW_W-1:0];
        w_p1  = CNT_W'(w_eff) + CNT_W'(1);
    end

    // ------------------------------------------------------------------
    // Line buffers: {upper, middle} per column in one RAM
    // ------------------------------------------------------------------
    slgs_ram #(
        .DEPTH (slgs_pkg::MAX_WIDTH),
        .WIDTH (WORD_W)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Arithmetic pipeline
    // ------------------------------------------------------------------
    slgs_filter u_filter (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (f_start),
        .take         (f_take),
        .window       (window_next),
        .sea_level    (sea_reg),
        .ctx          (ctx_reg),
        .result_valid (f_valid),
        .result       (f_result)
    );

    // ------------------------------------------------------------------
    // Sequencer: next state and datapath controls
    // ------------------------------------------------------------------
    always_comb begin
        logic               at_start;
        logic [CNT_W-1:0]   pend;
        logic [CNT_W-1:0]   vc;
        logic [COL_W-1:0]   oc;
        logic [ROW_W-1:0]   orow;
        logic               do_emit;
        logic               last;

        state_next   = state_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        sea_next     = sea_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        pending_next = pending_reg;
        addr_next    = addr_reg;
        value_next   = value_reg;
        emit_next    = emit_reg;
        ctx_next     = ctx_reg;
        window_next  = window_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;

        ram_re    = 1'b0;
        ram_raddr = '0;
        ram_we    = 1'b0;
        ram_wdata = '0;
        f_start   = 1'b0;
        f_take    = 1'b0;

        at_start = (in_col_reg == '0) && (in_row_reg == '0);
        pend     = pending_reg;
        oc       = out_col_reg;
        orow     = out_row_reg;
        do_emit  = 1'b0;
        vc       = '0;
        last     = 1'b0;

        case (state_reg)
            slgs_pkg::S_IDLE: begin
                if (in_xfer) begin
                    if (s_data.pad) begin
                        // flush one tail result as a zero sample of the next row
                        if (at_start && pending_reg != '0) begin
                            vc = w_p1 - pending_reg;
                            addr_next    = (vc >= CNT_W'(w_eff)) ? '0 : vc[ADDR_W-1:0];
                            value_next   = '0;
                            pending_next = pending_reg - CNT_W'(1);
                            do_emit      = 1'b1;
                            state_next   = slgs_pkg::S_READ;
                        end
                    end else begin
                        // drop a partly flushed tail at the start of a frame
                        if (at_start && pending_reg != w_p1) begin
                            pend = '0;
                            oc   = '0;
                            orow = '0;
                        end
                        addr_next  = in_col_reg;
                        value_next = s_data.sample_height;
                        if (in_col_reg >= w_m1) begin
                            in_col_next = '0;
                            in_row_next = (in_row_reg >= h_m1) ? '0 : in_row_reg + ROW_W'(1);
                        end else begin
                            in_col_next = in_col_reg + COL_W'(1);
                        end
                        if (pend >= w_p1) begin
                            do_emit      = 1'b1;
                            pending_next = pend;
                        end else begin
                            pending_next = pend + CNT_W'(1);
                        end
                        out_col_next = oc;
                        out_row_next = orow;
                        state_next   = slgs_pkg::S_READ;
                    end
                    ram_re    = 1'b1;
                    ram_raddr = addr_next;
                    emit_next = do_emit;
                    if (do_emit) begin
                        last = (orow >= h_m1) && (oc >= w_m1);
                        ctx_next.column    = oc;
                        ctx_next.row       = orow;
                        ctx_next.frame_end = last;
                        ctx_next.border    = (orow == '0) || (orow >= h_m1)
                                          || (oc == '0) || (oc >= w_m1);
                        if (oc >= w_m1) begin
                            out_col_next = '0;
                            out_row_next = last ? '0 : orow + ROW_W'(1);
                        end else begin
                            out_col_next = oc + COL_W'(1);
                            out_row_next = orow;
                        end
                    end
                end
            end

            slgs_pkg::S_READ: begin
                // advance the window and write the column back
                for (int k = 0; k < 3; k++) begin
                    window_next[k][0] = window_reg[k][1];
                    window_next[k][1] = window_reg[k][2];
                end
                window_next[0][2] = ram_rdata[WORD_W-1:HB];
                window_next[1][2] = ram_rdata[HB-1:0];
                window_next[2][2] = value_reg;
                ram_we    = 1'b1;
                ram_wdata = {ram_rdata[HB-1:0], value_reg};
                f_start   = emit_reg;
                state_next = emit_reg ? slgs_pkg::S_CALC : slgs_pkg::S_IDLE;
            end

            slgs_pkg::S_CALC: begin
                // hold the result in the filter until the output register frees up
                if (f_valid && (!m_valid_reg || m_ready)) begin
                    m_data_next  = f_result;
                    m_valid_next = 1'b1;
                    f_take       = 1'b1;
                    state_next   = slgs_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = slgs_pkg::S_IDLE;
            end
        endcase

        // configuration writes; a geometry write restarts the stream
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                slgs_pkg::REG_IMAGE_WIDTH: begin
                    width_next   = cfg_data[WCFG_W-1:0];
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                    pending_next = '0;
                end
                slgs_pkg::REG_IMAGE_HEIGHT: begin
                    height_next  = cfg_data[HCFG_W-1:0];
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                    pending_next = '0;
                end
                slgs_pkg::REG_SEA_LEVEL: begin
                    sea_next = cfg_data[HB-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= slgs_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= slgs_pkg::WIDTH_RESET;
            height_reg  <= slgs_pkg::HEIGHT_RESET;
            sea_reg     <= '0;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            pending_reg <= '0;
            emit_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    window_reg[r][c] <= '0;
                end
            end
        end else begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            sea_reg     <= sea_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            pending_reg <= pending_next;
            emit_reg    <= emit_next;
            m_valid_reg <= m_valid_next;
            window_reg  <= window_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg   <= addr_next;
        value_reg  <= value_next;
        ctx_reg    <= ctx_next;
        m_data_reg <= m_data_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_pending_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= w_p1)
        else $error("pending count beyond image_width+1");

    a_in_col_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        in_col_reg <= w_m1)
        else $error("input column beyond row width");

    a_filter_in_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        f_valid |-> state_reg == slgs_pkg::S_CALC)
        else $error("filter result outside calc state");

    a_result_from_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == slgs_pkg::S_CALC && f_valid))
        else $error("result loaded without a filter result");

endmodule

`default_nettype wire
